// ===== rtl/s5rp_pkg.sv =====
// ----------------------------------------------------------------------------
// s5rp_pkg
// Types and constants shared by the SOCKS5 request parser.
// ----------------------------------------------------------------------------
package s5rp_pkg;

	typedef enum logic [2:0] {
		PH_VER  = 3'd0,
		PH_CMD  = 3'd1,
		PH_RSV  = 3'd2,
		PH_ATYP = 3'd3,
		PH_ADDR = 3'd4,
		PH_PORT = 3'd5,
		PH_DONE = 3'd6,
		PH_ERR  = 3'd7
	} phase_t;

	localparam logic [7:0] SOCKS_VER = 8'd5;
	localparam logic [7:0] CMD_MIN   = 8'd1;
	localparam logic [7:0] CMD_MAX   = 8'd3;
	localparam logic [7:0] RSV_VAL   = 8'h00;
	localparam logic [7:0] ATYP_V4   = 8'd1;
	localparam logic [7:0] ATYP_NAME = 8'd3;
	localparam logic [7:0] ATYP_V6   = 8'd4;
	localparam logic [7:0] V4_LEN    = 8'd4;
	localparam logic [7:0] V6_LEN    = 8'd16;
	localparam logic [7:0] PORT_LEN  = 8'd2;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  command;
		logic [7:0]  addr_type;
		logic        addr_valid;
		logic [7:0]  addr_byte;
		logic [7:0]  addr_index;
		logic [7:0]  fqdn_length;
		logic [15:0] port;
	} res_t;

endpackage

// ===== rtl/socks5_request_parser.sv =====
// ----------------------------------------------------------------------------
// socks5_request_parser
// Walks a SOCKS5 request one byte per word and reports the parse state.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the input does not stall and gives one
// result word, which shows the parse state after that byte. That word is
// registered with the parse state when the byte is accepted. An output
// register with a skid register behind it lets the block keep taking bytes
// while a result waits; the input stalls only when both are full.
module socks5_request_parser
	import s5rp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  byte_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic [1:0]  command,
	output logic [7:0]  addr_type,
	output logic        addr_valid,
	output logic [7:0]  addr_byte,
	output logic [7:0]  addr_index,
	output logic [7:0]  fqdn_length,
	output logic [15:0] port
);

	phase_t      phase_q, phase_d;
	logic [7:0]  left_q, left_d;
	logic        await_q, await_d;
	logic [1:0]  cmd_q, cmd_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  nlen_q, nlen_d;
	logic [15:0] port_q, port_d;

	res_t res_d, out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic accept, out_take;
	logic [7:0] left_dec;

	assign accept    = req_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !res_stall;
	assign req_stall = skid_valid_q;
	assign left_dec  = left_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		await_d = await_q;
		cmd_d   = cmd_q;
		type_d  = type_q;
		pos_d   = pos_q;
		nlen_d  = nlen_q;
		port_d  = port_q;
		res_d.addr_valid = 1'b0;
		res_d.addr_byte  = 8'd0;
		res_d.addr_index = 8'd0;
		unique case (phase_q)
			PH_VER: begin
				phase_d = (byte_in == SOCKS_VER) ? PH_CMD : PH_ERR;
			end
			PH_CMD: begin
				if (byte_in >= CMD_MIN && byte_in <= CMD_MAX) begin
					cmd_d   = byte_in[1:0];
					phase_d = PH_RSV;
				end else begin
					phase_d = PH_ERR;
				end
			end
			PH_RSV: begin
				phase_d = (byte_in == RSV_VAL) ? PH_ATYP : PH_ERR;
			end
			PH_ATYP: begin
				type_d = byte_in;
				pos_d  = 8'd0;
				nlen_d = 8'd0;
				priority if (byte_in == ATYP_V4) begin
					left_d  = V4_LEN;
					phase_d = PH_ADDR;
				end else if (byte_in == ATYP_V6) begin
					left_d  = V6_LEN;
					phase_d = PH_ADDR;
				end else if (byte_in == ATYP_NAME) begin
					await_d = 1'b1;
					left_d  = 8'd0;
					phase_d = PH_ADDR;
				end else begin
					phase_d = PH_ERR;
				end
			end
			PH_ADDR: begin
				if (await_q) begin
					await_d = 1'b0;
					nlen_d  = byte_in;
					if (byte_in == 8'd0) begin
						left_d  = PORT_LEN;
						phase_d = PH_PORT;
					end else begin
						left_d = byte_in;
					end
				end else begin
					res_d.addr_valid = 1'b1;
					res_d.addr_byte  = byte_in;
					res_d.addr_index = pos_q;
					pos_d = pos_q + 8'd1;
					if (left_dec == 8'd0) begin
						left_d  = PORT_LEN;
						phase_d = PH_PORT;
					end else begin
						left_d = left_dec;
					end
				end
			end
			PH_PORT: begin
				port_d = {port_q[7:0], byte_in};
				left_d = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = PH_DONE;
				end
			end
			PH_DONE, PH_ERR: begin
			end
			default: begin
			end
		endcase
		unique case (phase_d)
			PH_DONE: res_d.status = ST_DONE;
			PH_ERR:  res_d.status = ST_ERR;
			default: res_d.status = ST_BUSY;
		endcase
		res_d.command     = cmd_d;
		res_d.addr_type   = type_d;
		res_d.fqdn_length = nlen_d;
		res_d.port        = port_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VER;
			left_q  <= 8'd0;
			await_q <= 1'b0;
			cmd_q   <= 2'd0;
			type_q  <= 8'd0;
			pos_q   <= 8'd0;
			nlen_q  <= 8'd0;
			port_q  <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			await_q <= await_d;
			cmd_q   <= cmd_d;
			type_q  <= type_d;
			pos_q   <= pos_d;
			nlen_q  <= nlen_d;
			port_q  <= port_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_d;
			end
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	assign res_valid   = out_valid_q;
	assign status      = out_q.status;
	assign command     = out_q.command;
	assign addr_type   = out_q.addr_type;
	assign addr_valid  = out_q.addr_valid;
	assign addr_byte   = out_q.addr_byte;
	assign addr_index  = out_q.addr_index;
	assign fqdn_length = out_q.fqdn_length;
	assign port        = out_q.port;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a word while the output register is empty");

	a_addr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && addr_valid) |-> (status == ST_BUSY))
		else $error("address byte reported with a finished status");

	a_final_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE || phase_q == PH_ERR) |=> $stable(phase_q))
		else $error("parser left its final state without reset");

	a_await_phase: assert property (@(posedge clk) disable iff (!arst_n)
		await_q |-> (phase_q == PH_ADDR))
		else $error("length byte pending outside the address phase");

endmodule

// ===== tb/sv/socks5_request_parser_tb.sv =====
// ----------------------------------------------------------------------------
// socks5_request_parser_tb
// Self-checking bench for the SOCKS5 request parser. A single reset is
// followed by one complete domain-name request of the longest length, with
// random command, port and name bytes (name opens 00, FF), then a long tail
// of random bytes that the finished parser must ignore. A scoreboard predicts
// every result word and checks it field by field. Both sides idle and stall
// in several phases, with a long receiver hold-off and a draining sender pause.
// ----------------------------------------------------------------------------
module socks5_request_parser_tb
	import s5rp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	class parse_scoreboard;
		phase_t      ph;
		logic [7:0]  left;
		logic        want_len;
		logic [1:0]  cmd;
		logic [7:0]  atyp;
		logic [7:0]  pos;
		logic [7:0]  name_len;
		logic [15:0] port_acc;
		res_t        expected_words[$];
		int          mismatches;

		function new();
			ph = PH_VER;
			left = '0;
			want_len = 1'b0;
			cmd = '0;
			atyp = '0;
			pos = '0;
			name_len = '0;
			port_acc = '0;
			mismatches = 0;
		endfunction

		function void take_byte(logic [7:0] b);
			res_t r;
			r = '0;
			case (ph)
				PH_VER: begin
					ph = (b == SOCKS_VER) ? PH_CMD : PH_ERR;
				end
				PH_CMD: begin
					if (b >= CMD_MIN && b <= CMD_MAX) begin
						cmd = b[1:0];
						ph = PH_RSV;
					end else begin
						ph = PH_ERR;
					end
				end
				PH_RSV: begin
					ph = (b == RSV_VAL) ? PH_ATYP : PH_ERR;
				end
				PH_ATYP: begin
					atyp = b;
					pos = '0;
					name_len = '0;
					if (b == ATYP_V4) begin
						left = V4_LEN;
						ph = PH_ADDR;
					end else if (b == ATYP_V6) begin
						left = V6_LEN;
						ph = PH_ADDR;
					end else if (b == ATYP_NAME) begin
						want_len = 1'b1;
						left = '0;
						ph = PH_ADDR;
					end else begin
						ph = PH_ERR;
					end
				end
				PH_ADDR: begin
					if (want_len) begin
						want_len = 1'b0;
						name_len = b;
						if (b == 8'd0) begin
							left = PORT_LEN;
							ph = PH_PORT;
						end else begin
							left = b;
						end
					end else begin
						r.addr_valid = 1'b1;
						r.addr_byte = b;
						r.addr_index = pos;
						pos = pos + 8'd1;
						left = left - 8'd1;
						if (left == 8'd0) begin
							left = PORT_LEN;
							ph = PH_PORT;
						end
					end
				end
				PH_PORT: begin
					port_acc = {port_acc[7:0], b};
					left = left - 8'd1;
					if (left == 8'd0)
						ph = PH_DONE;
				end
				default: begin
				end
			endcase
			if (ph == PH_DONE)
				r.status = ST_DONE;
			else if (ph == PH_ERR)
				r.status = ST_ERR;
			else
				r.status = ST_BUSY;
			r.command = cmd;
			r.addr_type = atyp;
			r.fqdn_length = name_len;
			r.port = port_acc;
			expected_words.push_back(r);
		endfunction

		function void compare(string name, logic [15:0] exp_val, logic [15:0] got_val);
			if (got_val !== exp_val) begin
				$error("%s: expected %0d, got %0d", name, exp_val, got_val);
				mismatches++;
			end
		endfunction

		function void check_word(res_t got);
			res_t e;
			if (expected_words.size() == 0) begin
				$error("result word with no byte pending");
				mismatches++;
				return;
			end
			e = expected_words.pop_front();
			compare("status", 16'(e.status), 16'(got.status));
			compare("command", 16'(e.command), 16'(got.command));
			compare("addr_type", 16'(e.addr_type), 16'(got.addr_type));
			compare("addr_valid", 16'(e.addr_valid), 16'(got.addr_valid));
			compare("addr_byte", 16'(e.addr_byte), 16'(got.addr_byte));
			compare("addr_index", 16'(e.addr_index), 16'(got.addr_index));
			compare("fqdn_length", 16'(e.fqdn_length), 16'(got.fqdn_length));
			compare("port", e.port, got.port);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [7:0]  byte_in;
	logic        res_valid;
	logic        res_stall;
	logic [1:0]  status;
	logic [1:0]  command;
	logic [7:0]  addr_type;
	logic        addr_valid;
	logic [7:0]  addr_byte;
	logic [7:0]  addr_index;
	logic [7:0]  fqdn_length;
	logic [15:0] port;

	parse_scoreboard sb = new();
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_start = 1'b0;

	socks5_request_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.byte_in(byte_in),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.command(command),
		.addr_type(addr_type),
		.addr_valid(addr_valid),
		.addr_byte(addr_byte),
		.addr_index(addr_index),
		.fqdn_length(fqdn_length),
		.port(port)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (req_stall);
		sb.take_byte(b);
	endtask

	task automatic set_mode(input int idx);
		case ((idx / 50) % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 78;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 78;
			end
			default: begin
				send_idle_pct = 23;
				recv_stall_pct = 23;
			end
		endcase
	endtask

	initial begin
		int hold;
		hold = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				sb.check_word('{status, command, addr_type, addr_valid, addr_byte,
					addr_index, fqdn_length, port});
			if (hold_start) begin
				hold_start = 1'b0;
				hold = 40;
			end
			if (hold > 0) begin
				hold--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		logic [7:0] stream[$];
		int i;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		byte_in <= 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stream.push_back(SOCKS_VER);
		stream.push_back(8'($urandom_range(CMD_MAX, CMD_MIN)));
		stream.push_back(RSV_VAL);
		stream.push_back(ATYP_NAME);
		stream.push_back(8'd255);
		stream.push_back(8'h00);
		stream.push_back(8'hFF);
		for (i = 2; i < 255; i++)
			stream.push_back(8'($urandom_range(255)));
		stream.push_back(8'($urandom_range(255)));
		stream.push_back(8'($urandom_range(255)));
		for (i = 0; i < 338; i++)
			stream.push_back(8'($urandom_range(255)));

		for (i = 0; i < stream.size(); i++) begin
			set_mode(i);
			if (i == 150) begin
				req_valid <= 1'b0;
				while (sb.expected_words.size() != 0)
					@(posedge clk);
			end
			if (i == 410)
				hold_start = 1'b1;
			send_byte(stream[i]);
		end
		req_valid <= 1'b0;

		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
